FILE: hdl/assert_macros.svh
// Assertion macros used by the backlight PWM controller RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, masked while reset is active.
`define BLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("blpwm assertion failed");
// Clocked check that also holds during reset.
`define BLP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("blpwm assertion failed");
`else
`define BLP_ASSERT(lbl, prop)
`define BLP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

FILE: hdl/blpwm_pkg.sv
// Types and constants of the backlight level PWM controller.
// No dependencies; used by every module of the block.
package blpwm_pkg;

  // Shared divider geometry
  localparam int DIV_W     = 44;
  localparam int DVS_W     = 12;
  localparam int QUO_W     = 32;
  localparam int STEP_W    = 6;
  localparam int LVL_STEPS = 22;
  localparam int CMP_STEPS = 44;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_ENABLE_PIN = 2'd3;

  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;
  localparam logic [32:0] FULL_ON    = 33'h1_0000_0000;

  typedef struct packed {
    logic [7:0] brightness;
    logic       suspended;
    logic       screen_blanked;
    logic [2:0] power_mode;
  } in_item_t;

  typedef struct packed {
    logic        level_changed;
    logic [11:0] new_level;
    logic [32:0] compare_value;
    logic        timer_running;
    logic        enable_pin;
    logic        start_sequence;
  } out_item_t;

  typedef struct packed {
    logic latch_in;
    logic div_start;
    logic div_sel;    // 0: level division, 1: compare division
    logic lvl_ld;
    logic mul_ld;
    logic out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic need_cmp;
  } dp_sts_t;

endpackage

FILE: hdl/blpwm_div.sv
// Restoring divider, one quotient bit per cycle, shared by both divisions.
// Depends on blpwm_pkg.
module blpwm_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [blpwm_pkg::STEP_W-1:0]      steps,
  input  logic [blpwm_pkg::DIV_W-1:0]       dividend,
  input  logic [blpwm_pkg::DVS_W-1:0]       divisor,
  output logic                              busy,
  output logic [blpwm_pkg::QUO_W-1:0]       quotient
);

  logic                            busy_r, busy_nxt;
  logic [blpwm_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [blpwm_pkg::DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [blpwm_pkg::DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [blpwm_pkg::DVS_W-1:0]     rem_r, rem_nxt;
  logic [blpwm_pkg::DVS_W:0]       rem_sh;
  logic [blpwm_pkg::DVS_W:0]       rem_sub;
  logic                            ge;

  // Shift in the next dividend bit and try the subtraction
  assign rem_sh  = {rem_r, dvd_r[blpwm_pkg::DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_r};
  assign ge      = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = steps;
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? rem_sub[blpwm_pkg::DVS_W-1:0] : rem_sh[blpwm_pkg::DVS_W-1:0];
      dvd_nxt  = {dvd_r[blpwm_pkg::DIV_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != {{(blpwm_pkg::STEP_W-1){1'b0}}, 1'b1});
    end
  end

  // Hold control under reset; operands need none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dvd_r[blpwm_pkg::QUO_W-1:0];

endmodule

FILE: hdl/blpwm_dp.sv
// Datapath: configuration registers, level scaling, compare value and state.
// Depends on blpwm_pkg and blpwm_div.
module blpwm_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [blpwm_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [blpwm_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  blpwm_pkg::in_item_t                 in_data,
  input  blpwm_pkg::dp_cmd_t                  cmd,
  output blpwm_pkg::dp_sts_t                  sts,
  output blpwm_pkg::out_item_t                out_data
);

  // Configuration registers
  logic [7:0]  max_bright_r;
  logic [11:0] max_level_r;
  logic [31:0] period_r;
  logic        has_en_r;

  // Item registers and block state
  logic [7:0]  bright_r;
  logic        force_r;
  logic [11:0] level_r;
  logic        changed_r;
  logic [43:0] prod_r;
  logic [11:0] cur_level_r;
  logic        chip_en_r;
  blpwm_pkg::out_item_t out_r;

  logic [7:0]  m_eff;
  logic [11:0] l_eff;
  logic [19:0] bl;
  logic [21:0] dvd1;
  logic [21:0] qlvl;
  logic [11:0] lvl_calc;
  logic [11:0] lvl_clamp;

  logic                             div_busy;
  logic [blpwm_pkg::QUO_W-1:0]      div_q;
  logic [blpwm_pkg::DIV_W-1:0]      div_dividend;
  logic [blpwm_pkg::DVS_W-1:0]      div_divisor;
  logic [blpwm_pkg::STEP_W-1:0]     div_steps;

  logic [31:0] cmp_sum;
  logic [32:0] cmp_val;
  logic        chip_en_new;

  // Treat zero limits as one
  assign m_eff = (max_bright_r == 8'd0) ? 8'd1 : max_bright_r;
  assign l_eff = (max_level_r == 12'd0) ? 12'd1 : max_level_r;

  // Level dividend 2*b*L + M, divisor 2*M
  assign bl   = {12'b0, bright_r} * {8'b0, l_eff};
  assign dvd1 = {1'b0, bl, 1'b0} + {14'b0, m_eff};

  // Select divider operands for the current division
  assign div_dividend = cmd.div_sel ? prod_r : {dvd1, 22'b0};
  assign div_divisor  = cmd.div_sel ? l_eff : {3'b0, m_eff, 1'b0};
  assign div_steps    = cmd.div_sel ? blpwm_pkg::STEP_W'(blpwm_pkg::CMP_STEPS)
                                    : blpwm_pkg::STEP_W'(blpwm_pkg::LVL_STEPS);

  blpwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .steps    (div_steps),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  // Raise nonzero brightness to one, clamp to L, then apply force-off
  assign qlvl = div_q[21:0];
  always_comb begin
    if (bright_r != 8'd0 && qlvl == 22'd0) begin
      lvl_clamp = 12'd1;
    end else if (qlvl > {10'b0, l_eff}) begin
      lvl_clamp = l_eff;
    end else begin
      lvl_clamp = qlvl[11:0];
    end
    lvl_calc = force_r ? 12'd0 : lvl_clamp;
  end

  assign sts.div_busy = div_busy;
  assign sts.need_cmp = (lvl_calc != cur_level_r) && (lvl_calc != 12'd0) &&
                        (lvl_calc != l_eff);

  // Compare value from the quotient plus reload
  assign cmp_sum = div_q + (blpwm_pkg::ALL_ONES32 - period_r);
  always_comb begin
    if (!changed_r || level_r == 12'd0) begin
      cmp_val = 33'd0;
    end else if (level_r == l_eff) begin
      cmp_val = blpwm_pkg::FULL_ON;
    end else begin
      cmp_val = {1'b0, cmp_sum};
    end
  end

  assign chip_en_new = changed_r ? (level_r != 12'd0) : chip_en_r;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bright_r <= 8'd255;
      max_level_r  <= 12'd255;
      period_r     <= 32'd0;
      has_en_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        blpwm_pkg::CFG_BRIGHT_LIMIT:   max_bright_r <= cfg_wdata[7:0];
        blpwm_pkg::CFG_MAX_LEVEL:      max_level_r  <= cfg_wdata[11:0];
        blpwm_pkg::CFG_PERIOD_TICKS:   period_r     <= cfg_wdata;
        blpwm_pkg::CFG_HAS_ENABLE_PIN: has_en_r     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Update stored level and chip enable when a result is issued
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_level_r <= 12'd0;
      chip_en_r   <= 1'b0;
    end else if (cmd.out_ld && changed_r) begin
      cur_level_r <= level_r;
      chip_en_r   <= (level_r != 12'd0);
    end
  end

  // Item payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      bright_r <= in_data.brightness;
      force_r  <= in_data.suspended | in_data.screen_blanked |
                  (in_data.power_mode != 3'd0);
    end
    if (cmd.lvl_ld) begin
      level_r   <= lvl_calc;
      changed_r <= (lvl_calc != cur_level_r);
    end
    if (cmd.mul_ld) begin
      prod_r <= {12'b0, period_r} * {32'b0, level_r};
    end
    if (cmd.out_ld) begin
      out_r.level_changed  <= changed_r;
      out_r.new_level      <= level_r;
      out_r.compare_value  <= cmp_val;
      out_r.timer_running  <= (level_r != 12'd0);
      out_r.enable_pin     <= has_en_r & chip_en_new;
      out_r.start_sequence <= changed_r && (level_r != 12'd0) && !chip_en_r;
    end
  end

  assign out_data = out_r;

endmodule

FILE: hdl/blpwm_ctrl.sv
// Controller state machine sequencing the datapath and the handshakes.
// Depends on blpwm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module blpwm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  blpwm_pkg::dp_sts_t  sts,
  output blpwm_pkg::dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LD1  = 3'd1;
  localparam logic [2:0] S_DIV1 = 3'd2;
  localparam logic [2:0] S_LVL  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_LD2  = 3'd5;
  localparam logic [2:0] S_DIV2 = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       out_free;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_LD1;
        end
      end
      S_LD1: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV1;
      end
      S_DIV1: begin
        if (!sts.div_busy) begin
          state_nxt = S_LVL;
        end
      end
      S_LVL: begin
        cmd.lvl_ld = 1'b1;
        state_nxt  = sts.need_cmp ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd.mul_ld = 1'b1;
        state_nxt  = S_LD2;
      end
      S_LD2: begin
        cmd.div_sel   = 1'b1;
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV2;
      end
      S_DIV2: begin
        cmd.div_sel = 1'b1;
        if (!sts.div_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.div_sel = 1'b1;
        if (out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Raise valid on load, drop it when the receiver takes the item
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `BLP_ASSERT(a_load_sets_valid, cmd.out_ld |=> out_valid_r)
  `BLP_ASSERT(a_accept_starts, accept |=> (state_r == S_LD1))
  `BLP_ASSERT(a_idle_div_quiet, (state_r == S_IDLE) |-> !sts.div_busy)
  `BLP_ASSERT(a_no_overwrite, (out_valid_r && !out_ready) |-> !cmd.out_ld)

endmodule

FILE: hdl/backlight_level_pwm_controller.sv
// Top level of the backlight level PWM controller.
// Depends on blpwm_pkg, blpwm_ctrl, blpwm_dp (which holds blpwm_div).
//
// Usage:
//   in_valid/in_ready/in_data carry one brightness request per item; each
//   request yields exactly one result item on out_valid/out_ready/out_data.
//   cfg_we/cfg_addr/cfg_wdata write the brightness limit (0), max_level (1),
//   period_ticks (2) and has_enable_pin (3) while the block is idle.
// Sequencing:
//   One item at a time: an unchanged, zero or full level needs only the
//   level division, and a new compare value also needs the multiply and
//   the compare division. The next item can be taken from the cycle in
//   which out_valid rises. The shared restoring divider runs 22 steps for
//   the level division and 44 for the compare division.
// Reset:
//   rst_n (synchronous, active low) restores register defaults, clears the
//   stored level and chip enable and empties the output register.
// Stall:
//   A finished result waits in the output register; the next item is
//   accepted and worked on meanwhile, and its result holds until taken.
module backlight_level_pwm_controller (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  blpwm_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output blpwm_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [blpwm_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [blpwm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  blpwm_pkg::dp_cmd_t cmd;
  blpwm_pkg::dp_sts_t sts;

  // Sequence the item through the datapath
  blpwm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Compute level, compare value and pin state
  blpwm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule
